@@ rtl/core/itmu_pkg.sv @@
package itmu_pkg;

    // Default working width of the datapath.
    localparam int DATA_WIDTH_DEF = 32;

    // Width of the interface payload fields.
    localparam int ACT_W = 4;
    localparam int FIELD_W = 32;

    // Operation codes of the request channel.
    typedef enum logic [ACT_W-1:0] {
        ACT_ADD    = 4'd0,
        ACT_SUB    = 4'd1,
        ACT_MUL    = 4'd2,
        ACT_DIV    = 4'd3,
        ACT_GCD    = 4'd4,
        ACT_LCM    = 4'd5,
        ACT_ISQRT  = 4'd6,
        ACT_POW    = 4'd7,
        ACT_MOD    = 4'd8,
        ACT_PRIME  = 4'd9,
        ACT_DIGSUM = 4'd10,
        ACT_TRISUM = 4'd11,
        ACT_LOG    = 4'd12,
        ACT_ABS    = 4'd13
    } t_action;

    // Controller states.
    typedef enum logic [4:0] {
        S_IDLE, S_DISP, S_FIN,
        S_MUL_W, S_MUL_WB, S_TS_GO,
        S_DIV_W, S_DIV_WB,
        S_GCD, S_GCD_END, S_LCM_GO, S_LCM_W, S_LCM_P, S_LCM_D,
        S_SQ,
        S_PW, S_PW_W1, S_PW_B, S_PW_SQ, S_PW_W2, S_PW_NX,
        S_PR, S_PR_W, S_PR_CHK,
        S_DS, S_DS_W, S_DS_WB,
        S_LG, S_LG_W, S_LG_WB
    } t_state;

    // Datapath commands issued by the controller.
    typedef enum logic [4:0] {
        OP_NOP, OP_LOAD, OP_ADD, OP_SUB, OP_ABS, OP_ERR,
        OP_ACC_X, OP_ACC_ONES, OP_ACC_ONE, OP_ACC_ZERO,
        OP_ACC_P, OP_ACC_Q, OP_ACC_R,
        OP_MUL_XY, OP_MUL_AB, OP_MUL_AX, OP_MUL_XX,
        OP_DIV_XY, OP_DIV_XA, OP_DIV_X10,
        OP_X_P, OP_GCD, OP_GCD_END, OP_SQ_INIT, OP_SQ, OP_PW_NEXT,
        OP_Y2, OP_YINC, OP_DS_ACC, OP_TS_PREP, OP_LG_ACC, OP_OUT
    } t_dp_op;

    // Datapath status seen by the controller.
    typedef struct packed {
        logic x_neg;
        logic y_neg;
        logic x_zero;
        logic y_zero;
        logic y_le1;
        logic x_lt2;
        logic y_odd;
        logic x_ge_y;
        logic unit_done;
        logic q_ge_y;
        logic rem_zero;
    } t_stat;

endpackage

@@ rtl/core/itmu_if.sv @@
// Request channel: operation code and two operands.
interface itmu_req_if;
    logic                                    valid;
    logic                                    ready;
    logic [itmu_pkg::ACT_W-1:0]              action;
    logic signed [itmu_pkg::FIELD_W-1:0]     operand_a;
    logic signed [itmu_pkg::FIELD_W-1:0]     operand_b;

    modport source (output valid, action, operand_a, operand_b, input ready);
    modport sink (input valid, action, operand_a, operand_b, output ready);
endinterface

// Response channel: result and error flag.
interface itmu_rsp_if;
    logic                                    valid;
    logic                                    ready;
    logic signed [itmu_pkg::FIELD_W-1:0]     result;
    logic                                    error;

    modport source (output valid, result, error, input ready);
    modport sink (input valid, result, error, output ready);
endinterface

@@ rtl/core/itmu_seq_unit.sv @@
// Shared shift-add multiplier and restoring divider, one bit per cycle.
module itmu_seq_unit #(
    parameter int DATA_WIDTH = itmu_pkg::DATA_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic                  i_is_div,
    input  logic [DATA_WIDTH-1:0] i_opa,
    input  logic [DATA_WIDTH-1:0] i_opb,
    output logic                  o_done,
    output logic [DATA_WIDTH-1:0] o_prod,
    output logic [DATA_WIDTH-1:0] o_quo,
    output logic [DATA_WIDTH-1:0] o_rem
);
    localparam int W = DATA_WIDTH;
    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  r_hi, r_lo, r_sh;
    logic [CW-1:0] r_cnt;
    logic          r_div, r_done;
    logic [W:0]    w_trial;
    logic [W:0]    w_shift;

    // Trial subtraction for the divider step.
    assign w_shift = {r_hi, r_lo[W-1]};
    assign w_trial = w_shift - {1'b0, r_sh};

    // Control: bit counter and done flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_cnt  <= CW'(W);
            r_done <= 1'b0;
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - CW'(1);
            if (r_cnt == CW'(1)) begin
                r_done <= 1'b1;
            end
        end
    end

    // Operand and partial result registers.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_div <= i_is_div;
            r_hi  <= '0;
            r_lo  <= i_opa;
            r_sh  <= i_opb;
        end else if (r_cnt != '0) begin
            if (r_div) begin
                if (!w_trial[W]) begin
                    r_hi <= w_trial[W-1:0];
                    r_lo <= {r_lo[W-2:0], 1'b1};
                end else begin
                    r_hi <= w_shift[W-1:0];
                    r_lo <= {r_lo[W-2:0], 1'b0};
                end
            end else begin
                if (r_sh[0]) begin
                    r_hi <= r_hi + r_lo;
                end
                r_lo <= {r_lo[W-2:0], 1'b0};
                r_sh <= {1'b0, r_sh[W-1:1]};
            end
        end
    end

    assign o_done = r_done;
    assign o_prod = r_hi;
    assign o_quo  = r_lo;
    assign o_rem  = r_hi;

endmodule

@@ rtl/core/itmu_datapath.sv @@
// Working registers, the simple register operations and the shared unit.
module itmu_datapath #(
    parameter int DATA_WIDTH = itmu_pkg::DATA_WIDTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  itmu_pkg::t_dp_op                    i_op,
    input  logic signed [itmu_pkg::FIELD_W-1:0] i_operand_a,
    input  logic signed [itmu_pkg::FIELD_W-1:0] i_operand_b,
    output itmu_pkg::t_stat                     o_stat,
    output logic signed [itmu_pkg::FIELD_W-1:0] o_result,
    output logic                                o_error
);
    localparam int W = DATA_WIDTH;
    localparam int KW = $clog2(W);
    localparam int SQ_TOP = 2 * ((W - 1) / 2);

    logic [W-1:0]  r_x, r_y, r_ra, r_rb, r_acc, r_res;
    logic [KW-1:0] r_k;
    logic          r_err, r_res_err;

    logic          w_start, w_is_div, w_done;
    logic [W-1:0]  w_opa, w_opb, w_prod, w_quo, w_rem;
    logic [W:0]    w_sq_t;

    // Operand selection for the shared unit.
    always_comb begin
        w_start  = 1'b0;
        w_is_div = 1'b0;
        w_opa    = r_x;
        w_opb    = r_y;
        case (i_op)
            itmu_pkg::OP_MUL_XY: begin
                w_start = 1'b1;
            end
            itmu_pkg::OP_MUL_AB: begin
                w_start = 1'b1;
                w_opa   = r_ra;
                w_opb   = r_rb;
            end
            itmu_pkg::OP_MUL_AX: begin
                w_start = 1'b1;
                w_opa   = r_acc;
                w_opb   = r_x;
            end
            itmu_pkg::OP_MUL_XX: begin
                w_start = 1'b1;
                w_opb   = r_x;
            end
            itmu_pkg::OP_DIV_XY: begin
                w_start  = 1'b1;
                w_is_div = 1'b1;
            end
            itmu_pkg::OP_DIV_XA: begin
                w_start  = 1'b1;
                w_is_div = 1'b1;
                w_opb    = r_acc;
            end
            itmu_pkg::OP_DIV_X10: begin
                w_start  = 1'b1;
                w_is_div = 1'b1;
                w_opb    = W'(10);
            end
            default: begin
                w_start = 1'b0;
            end
        endcase
    end

    itmu_seq_unit #(
        .DATA_WIDTH(W)
    ) u_unit (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_start),
        .i_is_div (w_is_div),
        .i_opa    (w_opa),
        .i_opb    (w_opb),
        .o_done   (w_done),
        .o_prod   (w_prod),
        .o_quo    (w_quo),
        .o_rem    (w_rem)
    );

    // Square root step: trial value is root plus current bit.
    assign w_sq_t = {1'b0, r_acc} + {1'b0, r_y};

    // Working registers.
    always_ff @(posedge i_clk) begin
        case (i_op)
            itmu_pkg::OP_LOAD: begin
                r_x   <= W'($signed(i_operand_a));
                r_y   <= W'($signed(i_operand_b));
                r_ra  <= W'($signed(i_operand_a));
                r_rb  <= W'($signed(i_operand_b));
                r_acc <= '0;
                r_err <= 1'b0;
                r_k   <= '0;
            end
            itmu_pkg::OP_ADD:      r_acc <= r_x + r_y;
            itmu_pkg::OP_SUB:      r_acc <= r_x - r_y;
            itmu_pkg::OP_ABS:      r_acc <= r_x[W-1] ? (W'(0) - r_x) : r_x;
            itmu_pkg::OP_ERR: begin
                r_acc <= '0;
                r_err <= 1'b1;
            end
            itmu_pkg::OP_ACC_X:    r_acc <= r_x;
            itmu_pkg::OP_ACC_ONES: r_acc <= '1;
            itmu_pkg::OP_ACC_ONE:  r_acc <= W'(1);
            itmu_pkg::OP_ACC_ZERO: r_acc <= '0;
            itmu_pkg::OP_ACC_P:    r_acc <= w_prod;
            itmu_pkg::OP_ACC_Q:    r_acc <= w_quo;
            itmu_pkg::OP_ACC_R:    r_acc <= w_rem;
            itmu_pkg::OP_X_P:      r_x <= w_prod;
            itmu_pkg::OP_GCD: begin
                // Binary gcd step; stops changing once x reaches zero.
                if (r_x != '0) begin
                    if (!r_x[0] && !r_y[0]) begin
                        r_x <= r_x >> 1;
                        r_y <= r_y >> 1;
                        r_k <= r_k + KW'(1);
                    end else if (!r_x[0]) begin
                        r_x <= r_x >> 1;
                    end else if (!r_y[0]) begin
                        r_y <= r_y >> 1;
                    end else if (r_x >= r_y) begin
                        r_x <= (r_x - r_y) >> 1;
                    end else begin
                        r_y <= (r_y - r_x) >> 1;
                    end
                end
            end
            itmu_pkg::OP_GCD_END:  r_acc <= r_y << r_k;
            itmu_pkg::OP_SQ_INIT:  r_y <= {{(W-1){1'b0}}, 1'b1} << SQ_TOP;
            itmu_pkg::OP_SQ: begin
                if ({1'b0, r_x} >= w_sq_t) begin
                    r_x   <= r_x - w_sq_t[W-1:0];
                    r_acc <= (r_acc >> 1) + r_y;
                end else begin
                    r_acc <= r_acc >> 1;
                end
                r_y <= r_y >> 2;
            end
            itmu_pkg::OP_PW_NEXT: begin
                r_x <= w_prod;
                r_y <= r_y >> 1;
            end
            itmu_pkg::OP_Y2:       r_y <= W'(2);
            itmu_pkg::OP_YINC:     r_y <= r_y + W'(1);
            itmu_pkg::OP_DS_ACC: begin
                r_acc <= r_acc + w_rem;
                r_x   <= w_quo;
            end
            itmu_pkg::OP_TS_PREP: begin
                // Halve whichever factor is even.
                if (!r_x[0]) begin
                    r_x <= r_x >> 1;
                    r_y <= r_x + W'(1);
                end else begin
                    r_y <= (r_x + W'(1)) >> 1;
                end
            end
            itmu_pkg::OP_LG_ACC: begin
                r_x   <= w_quo;
                r_acc <= r_acc + W'(1);
            end
            default: begin
                r_acc <= r_acc;
            end
        endcase
    end

    // Result register feeding the response channel.
    always_ff @(posedge i_clk) begin
        if (i_op == itmu_pkg::OP_OUT) begin
            r_res     <= r_acc;
            r_res_err <= r_err;
        end
    end

    // Status toward the controller.
    always_comb begin
        o_stat.x_neg     = r_x[W-1];
        o_stat.y_neg     = r_y[W-1];
        o_stat.x_zero    = (r_x == '0);
        o_stat.y_zero    = (r_y == '0);
        o_stat.y_le1     = r_y[W-1] || (r_y == '0) || (r_y == W'(1));
        o_stat.x_lt2     = (r_x < W'(2));
        o_stat.y_odd     = r_y[0];
        o_stat.x_ge_y    = (r_x >= r_y);
        o_stat.unit_done = w_done;
        o_stat.q_ge_y    = (w_quo >= r_y);
        o_stat.rem_zero  = (w_rem == '0);
    end

    assign o_result = itmu_pkg::FIELD_W'($signed(r_res));
    assign o_error  = r_res_err;

endmodule

@@ rtl/core/itmu_ctrl.sv @@
// Sequencer that steps each operation through the datapath.
module itmu_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [itmu_pkg::ACT_W-1:0]  i_action,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    input  itmu_pkg::t_stat             i_stat,
    output itmu_pkg::t_dp_op            o_op
);
    itmu_pkg::t_state  r_state, n_state;
    itmu_pkg::t_action r_action;
    logic              r_out_valid, n_out_valid;
    logic              w_accept, w_out_free;

    assign o_in_ready  = (r_state == itmu_pkg::S_IDLE);
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_out_free  = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign n_out_valid = (o_op == itmu_pkg::OP_OUT) || (r_out_valid && !i_out_ready);

    // State and response valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= itmu_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_action <= itmu_pkg::t_action'(i_action);
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            itmu_pkg::S_IDLE: if (w_accept) n_state = itmu_pkg::S_DISP;
            itmu_pkg::S_DISP: begin
                n_state = itmu_pkg::S_FIN;
                case (r_action)
                    itmu_pkg::ACT_MUL: n_state = itmu_pkg::S_MUL_W;
                    itmu_pkg::ACT_DIV, itmu_pkg::ACT_MOD: begin
                        if (!i_stat.y_neg && !i_stat.y_zero && !i_stat.x_neg) begin
                            n_state = itmu_pkg::S_DIV_W;
                        end
                    end
                    itmu_pkg::ACT_GCD, itmu_pkg::ACT_LCM: begin
                        if (!i_stat.x_neg && !i_stat.y_neg && !i_stat.y_zero) begin
                            n_state = itmu_pkg::S_GCD;
                        end
                    end
                    itmu_pkg::ACT_ISQRT: if (!i_stat.x_neg) n_state = itmu_pkg::S_SQ;
                    itmu_pkg::ACT_POW: if (!i_stat.y_neg) n_state = itmu_pkg::S_PW;
                    itmu_pkg::ACT_PRIME: begin
                        if (!i_stat.x_neg && !i_stat.x_lt2) n_state = itmu_pkg::S_PR;
                    end
                    itmu_pkg::ACT_DIGSUM: if (!i_stat.x_neg) n_state = itmu_pkg::S_DS;
                    itmu_pkg::ACT_TRISUM: if (!i_stat.x_neg) n_state = itmu_pkg::S_TS_GO;
                    itmu_pkg::ACT_LOG: begin
                        if (!i_stat.y_le1 && !i_stat.x_neg) n_state = itmu_pkg::S_LG;
                    end
                    default: n_state = itmu_pkg::S_FIN;
                endcase
            end
            itmu_pkg::S_FIN: if (w_out_free) n_state = itmu_pkg::S_IDLE;
            itmu_pkg::S_TS_GO:  n_state = itmu_pkg::S_MUL_W;
            itmu_pkg::S_MUL_W:  if (i_stat.unit_done) n_state = itmu_pkg::S_MUL_WB;
            itmu_pkg::S_MUL_WB: n_state = itmu_pkg::S_FIN;
            itmu_pkg::S_DIV_W:  if (i_stat.unit_done) n_state = itmu_pkg::S_DIV_WB;
            itmu_pkg::S_DIV_WB: n_state = itmu_pkg::S_FIN;
            itmu_pkg::S_GCD:    if (i_stat.x_zero) n_state = itmu_pkg::S_GCD_END;
            itmu_pkg::S_GCD_END: begin
                n_state = (r_action == itmu_pkg::ACT_GCD) ? itmu_pkg::S_FIN
                                                           : itmu_pkg::S_LCM_GO;
            end
            itmu_pkg::S_LCM_GO: n_state = itmu_pkg::S_LCM_W;
            itmu_pkg::S_LCM_W:  if (i_stat.unit_done) n_state = itmu_pkg::S_LCM_P;
            itmu_pkg::S_LCM_P:  n_state = itmu_pkg::S_LCM_D;
            itmu_pkg::S_LCM_D: begin
                n_state = i_stat.x_neg ? itmu_pkg::S_FIN : itmu_pkg::S_DIV_W;
            end
            itmu_pkg::S_SQ:     if (i_stat.y_zero) n_state = itmu_pkg::S_FIN;
            itmu_pkg::S_PW: begin
                if (i_stat.y_zero) begin
                    n_state = itmu_pkg::S_FIN;
                end else if (i_stat.y_odd) begin
                    n_state = itmu_pkg::S_PW_W1;
                end else begin
                    n_state = itmu_pkg::S_PW_W2;
                end
            end
            itmu_pkg::S_PW_W1:  if (i_stat.unit_done) n_state = itmu_pkg::S_PW_B;
            itmu_pkg::S_PW_B:   n_state = itmu_pkg::S_PW_SQ;
            itmu_pkg::S_PW_SQ:  n_state = itmu_pkg::S_PW_W2;
            itmu_pkg::S_PW_W2:  if (i_stat.unit_done) n_state = itmu_pkg::S_PW_NX;
            itmu_pkg::S_PW_NX:  n_state = itmu_pkg::S_PW;
            itmu_pkg::S_PR:     n_state = itmu_pkg::S_PR_W;
            itmu_pkg::S_PR_W:   if (i_stat.unit_done) n_state = itmu_pkg::S_PR_CHK;
            itmu_pkg::S_PR_CHK: begin
                if (!i_stat.q_ge_y || i_stat.rem_zero) begin
                    n_state = itmu_pkg::S_FIN;
                end else begin
                    n_state = itmu_pkg::S_PR;
                end
            end
            itmu_pkg::S_DS: begin
                n_state = i_stat.x_zero ? itmu_pkg::S_FIN : itmu_pkg::S_DS_W;
            end
            itmu_pkg::S_DS_W:   if (i_stat.unit_done) n_state = itmu_pkg::S_DS_WB;
            itmu_pkg::S_DS_WB:  n_state = itmu_pkg::S_DS;
            itmu_pkg::S_LG: begin
                n_state = i_stat.x_ge_y ? itmu_pkg::S_LG_W : itmu_pkg::S_FIN;
            end
            itmu_pkg::S_LG_W:   if (i_stat.unit_done) n_state = itmu_pkg::S_LG_WB;
            itmu_pkg::S_LG_WB:  n_state = itmu_pkg::S_LG;
            default:            n_state = itmu_pkg::S_IDLE;
        endcase
    end

    // Datapath command for the current state.
    always_comb begin
        o_op = itmu_pkg::OP_NOP;
        case (r_state)
            itmu_pkg::S_IDLE: if (w_accept) o_op = itmu_pkg::OP_LOAD;
            itmu_pkg::S_DISP: begin
                case (r_action)
                    itmu_pkg::ACT_ADD: o_op = itmu_pkg::OP_ADD;
                    itmu_pkg::ACT_SUB: o_op = itmu_pkg::OP_SUB;
                    itmu_pkg::ACT_ABS: o_op = itmu_pkg::OP_ABS;
                    itmu_pkg::ACT_MUL: o_op = itmu_pkg::OP_MUL_XY;
                    itmu_pkg::ACT_DIV, itmu_pkg::ACT_MOD: begin
                        if (i_stat.y_neg || i_stat.y_zero) begin
                            o_op = itmu_pkg::OP_ERR;
                        end else if (i_stat.x_neg) begin
                            // Negative dividend: quotient 0, remainder a.
                            o_op = (r_action == itmu_pkg::ACT_MOD) ? itmu_pkg::OP_ACC_X
                                                                    : itmu_pkg::OP_NOP;
                        end else begin
                            o_op = itmu_pkg::OP_DIV_XY;
                        end
                    end
                    itmu_pkg::ACT_GCD, itmu_pkg::ACT_LCM: begin
                        if (i_stat.x_neg || i_stat.y_neg || i_stat.y_zero) begin
                            o_op = itmu_pkg::OP_ERR;
                        end
                    end
                    itmu_pkg::ACT_ISQRT: begin
                        o_op = i_stat.x_neg ? itmu_pkg::OP_ACC_ONES : itmu_pkg::OP_SQ_INIT;
                    end
                    itmu_pkg::ACT_POW: begin
                        o_op = i_stat.y_neg ? itmu_pkg::OP_ERR : itmu_pkg::OP_ACC_ONE;
                    end
                    itmu_pkg::ACT_PRIME: begin
                        if (!i_stat.x_neg && !i_stat.x_lt2) o_op = itmu_pkg::OP_Y2;
                    end
                    itmu_pkg::ACT_DIGSUM: if (i_stat.x_neg) o_op = itmu_pkg::OP_ERR;
                    itmu_pkg::ACT_TRISUM: begin
                        o_op = i_stat.x_neg ? itmu_pkg::OP_ERR : itmu_pkg::OP_TS_PREP;
                    end
                    itmu_pkg::ACT_LOG: if (i_stat.y_le1) o_op = itmu_pkg::OP_ERR;
                    default: o_op = itmu_pkg::OP_ERR;
                endcase
            end
            itmu_pkg::S_FIN:     if (w_out_free) o_op = itmu_pkg::OP_OUT;
            itmu_pkg::S_TS_GO:   o_op = itmu_pkg::OP_MUL_XY;
            itmu_pkg::S_MUL_WB:  o_op = itmu_pkg::OP_ACC_P;
            itmu_pkg::S_DIV_WB: begin
                o_op = (r_action == itmu_pkg::ACT_MOD) ? itmu_pkg::OP_ACC_R
                                                        : itmu_pkg::OP_ACC_Q;
            end
            itmu_pkg::S_GCD:     if (!i_stat.x_zero) o_op = itmu_pkg::OP_GCD;
            itmu_pkg::S_GCD_END: o_op = itmu_pkg::OP_GCD_END;
            itmu_pkg::S_LCM_GO:  o_op = itmu_pkg::OP_MUL_AB;
            itmu_pkg::S_LCM_P:   o_op = itmu_pkg::OP_X_P;
            itmu_pkg::S_LCM_D: begin
                // A product that wraps negative gives 0.
                o_op = i_stat.x_neg ? itmu_pkg::OP_ACC_ZERO : itmu_pkg::OP_DIV_XA;
            end
            itmu_pkg::S_SQ:      if (!i_stat.y_zero) o_op = itmu_pkg::OP_SQ;
            itmu_pkg::S_PW: begin
                if (!i_stat.y_zero) begin
                    o_op = i_stat.y_odd ? itmu_pkg::OP_MUL_AX : itmu_pkg::OP_MUL_XX;
                end
            end
            itmu_pkg::S_PW_B:    o_op = itmu_pkg::OP_ACC_P;
            itmu_pkg::S_PW_SQ:   o_op = itmu_pkg::OP_MUL_XX;
            itmu_pkg::S_PW_NX:   o_op = itmu_pkg::OP_PW_NEXT;
            itmu_pkg::S_PR:      o_op = itmu_pkg::OP_DIV_XY;
            itmu_pkg::S_PR_CHK: begin
                // Divisor past the square root means a is prime.
                if (!i_stat.q_ge_y) begin
                    o_op = itmu_pkg::OP_ACC_ONE;
                end else if (!i_stat.rem_zero) begin
                    o_op = itmu_pkg::OP_YINC;
                end
            end
            itmu_pkg::S_DS:      if (!i_stat.x_zero) o_op = itmu_pkg::OP_DIV_X10;
            itmu_pkg::S_DS_WB:   o_op = itmu_pkg::OP_DS_ACC;
            itmu_pkg::S_LG:      if (i_stat.x_ge_y) o_op = itmu_pkg::OP_DIV_XY;
            itmu_pkg::S_LG_WB:   o_op = itmu_pkg::OP_LG_ACC;
            default:             o_op = itmu_pkg::OP_NOP;
        endcase
    end

endmodule

@@ rtl/core/iterative_integer_math_unit_core.sv @@
// Operations: add, sub and abs are done directly in the datapath; mul, div,
// mod and trisum run the shared bit-serial unit once; gcd iterates binary steps;
// pow runs a multiply for each set exponent bit and a squaring for each bit; prime
// divides by each trial divisor up to sqrt(a); digit sum divides by ten per digit and log by b per step.
// Requests are taken one operation at a time, only while the sequencer is idle.
// Reset (synchronous, active low) clears the sequencer and the unit counter.
module iterative_integer_math_unit_core #(
    parameter int DATA_WIDTH = itmu_pkg::DATA_WIDTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    itmu_req_if.sink   i_req,
    itmu_rsp_if.source o_rsp
);
    itmu_pkg::t_dp_op w_op;
    itmu_pkg::t_stat  w_stat;

    // Sequencer.
    itmu_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .i_action    (i_req.action),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .i_stat      (w_stat),
        .o_op        (w_op)
    );

    // Datapath.
    itmu_datapath #(
        .DATA_WIDTH(DATA_WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_op        (w_op),
        .i_operand_a (i_req.operand_a),
        .i_operand_b (i_req.operand_b),
        .o_stat      (w_stat),
        .o_result    (o_rsp.result),
        .o_error     (o_rsp.error)
    );

endmodule
